@@ design/lms_pkg.sv @@
// Package for the longest monotone subsequence block: sizes, the token that
// travels down the cell chain, and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lms_pkg;

  localparam int MAX_LEN = 64;
  localparam int VAL_W   = 16;
  localparam int LEN_W   = 7;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        remaining;  // occupied cells still ahead
    logic [LEN_W-1:0]        top;        // best qualifying length seen
    logic                    placed;
    logic                    last;
  } token_t;

  typedef struct packed {
    logic [LEN_W-1:0] length_here;
    logic [LEN_W-1:0] longest_so_far;
    logic             final_result;
    logic             dropped;
  } result_t;

endpackage
`default_nettype wire

@@ design/lms_if.sv @@
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on lms_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lms_in_if;
  import lms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sample_value;
  logic                    end_of_sequence;

  modport source (output valid, output sample_value, output end_of_sequence, input ready);
  modport sink   (input valid, input sample_value, input end_of_sequence, output ready);
endinterface

interface lms_out_if;
  import lms_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] length_here;
  logic [LEN_W-1:0] longest_so_far;
  logic             final_result;
  logic             dropped;

  modport source (output valid, output length_here, output longest_so_far,
                  output final_result, output dropped, input ready);
  modport sink   (input valid, input length_here, input longest_so_far,
                  input final_result, input dropped, output ready);
endinterface
`default_nettype wire

@@ design/lms_cell.sv @@
// One chain cell: holds a stored value and its subsequence length, updates
// the passing token and registers it for the next cell.
// Depends on lms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lms_cell
  import lms_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   direction_i,
  input  wire token_t tok_i,
  output token_t      tok_o
);

  token_t                  tok_q, tok_d;
  logic signed [VAL_W-1:0] val_q;
  logic [LEN_W-1:0]        len_q;
  logic                    hit;
  logic                    store;

  always_comb begin
    tok_d = tok_i;
    store = 1'b0;
    hit   = direction_i ? (val_q > tok_i.value) : (val_q < tok_i.value);
    if (tok_i.valid) begin
      if (tok_i.remaining != '0) begin
        tok_d.remaining = tok_i.remaining - 1'b1;
        if (hit && (len_q > tok_i.top)) begin
          tok_d.top = len_q;
        end
      end else if (!tok_i.placed) begin
        store        = 1'b1;
        tok_d.placed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      val_q <= tok_i.value;
      len_q <= tok_i.top + 1'b1;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

@@ design/lms_chain.sv @@
// Row of MAX_LEN cells; a token enters at the head and leaves at the tail,
// registered once in each cell on the way.
// Depends on lms_pkg and lms_cell.
`timescale 1ns / 1ps
`default_nettype none
module lms_chain
  import lms_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   direction_i,
  input  wire token_t tok_i,
  output token_t      tok_o
);

  token_t link [MAX_LEN+1];

  assign link[0] = tok_i;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    lms_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .direction_i (direction_i),
      .tok_i       (link[g]),
      .tok_o       (link[g+1])
    );
  end

  assign tok_o = link[MAX_LEN];

endmodule
`default_nettype wire

@@ design/longest_monotone_subsequence.sv @@
// Longest strictly monotone subsequence tracker.
// The token walks the chain, registered in each cell, and its result is then registered in the output register.
// Only one sample is in the chain at a time.
// A finished result may wait in the output register while the next sample is taken; a second
// result held behind it keeps the input stalled until the receiver takes the first.
// Reset clears entry count, best length, direction and handshake state; cell contents
// are left undefined and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none
module longest_monotone_subsequence
  import lms_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  lms_in_if.sink     sample_i,
  lms_out_if.source  result_o
);

  logic             dir_q;
  logic             busy_q;
  logic [CNT_W-1:0] count_q;
  logic [LEN_W-1:0] best_q;
  logic             hold_valid_q;
  result_t          hold_q;
  logic             out_valid_q;
  result_t          out_q;

  token_t           tok_in;
  token_t           tok_out;
  logic             accept;
  logic             out_free;
  logic [LEN_W-1:0] here;
  logic [LEN_W-1:0] best_d;
  result_t          res_d;

  assign sample_i.ready = !busy_q;
  assign accept         = sample_i.valid && !busy_q;

  always_comb begin
    tok_in.valid     = accept;
    tok_in.value     = sample_i.sample_value;
    tok_in.remaining = count_q;
    tok_in.top       = '0;
    tok_in.placed    = 1'b0;
    tok_in.last      = sample_i.end_of_sequence;
  end

  lms_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (dir_q),
    .tok_i       (tok_in),
    .tok_o       (tok_out)
  );

  always_comb begin
    here                 = tok_out.placed ? (tok_out.top + 1'b1) : '0;
    best_d               = (here > best_q) ? here : best_q;
    res_d.length_here    = here;
    res_d.longest_so_far = best_d;
    res_d.final_result   = tok_out.last;
    res_d.dropped        = !tok_out.placed;
  end

  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q        <= 1'b0;
      busy_q       <= 1'b0;
      count_q      <= '0;
      best_q       <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (tok_out.valid) begin
        if (tok_out.last) begin
          count_q <= '0;
          best_q  <= '0;
        end else begin
          count_q <= count_q + CNT_W'(tok_out.placed);
          best_q  <= best_d;
        end
      end
      if (hold_valid_q && out_free) begin
        out_valid_q  <= 1'b1;
        hold_valid_q <= 1'b0;
        busy_q       <= 1'b0;
      end else if (tok_out.valid) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
          busy_q      <= 1'b0;
        end else begin
          hold_valid_q <= 1'b1;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_valid_q && out_free) begin
      out_q <= hold_q;
    end else if (tok_out.valid) begin
      if (out_free) begin
        out_q <= res_d;
      end else begin
        hold_q <= res_d;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.length_here    = out_q.length_here;
  assign result_o.longest_so_far = out_q.longest_so_far;
  assign result_o.final_result   = out_q.final_result;
  assign result_o.dropped        = out_q.dropped;

endmodule
`default_nettype wire
